// ===== src/dbn_pkg.sv =====
// ----------------------------------------------------------------------------
// dbn_pkg: shared types and constants
// Item, result, configuration and cell types for the box decode and
// per-class suppression block.
// ----------------------------------------------------------------------------
package dbn_pkg;

  localparam int MAX_BOXES = 64;
  localparam int COUNT_W   = $clog2(MAX_BOXES + 1);

  // configuration register indexes
  localparam logic [2:0] CFG_CONF_THR = 3'd0;
  localparam logic [2:0] CFG_IOU_THR  = 3'd1;
  localparam logic [2:0] CFG_OFFSET_X = 3'd2;
  localparam logic [2:0] CFG_OFFSET_Y = 3'd3;
  localparam logic [2:0] CFG_SCALE_X  = 3'd4;
  localparam logic [2:0] CFG_SCALE_Y  = 3'd5;

  typedef struct packed {
    logic [15:0] raw_cx;
    logic [15:0] raw_cy;
    logic [15:0] raw_w;
    logic [15:0] raw_h;
    logic [15:0] confidence;
    logic [6:0]  class_id;
    logic        frame_end;
  } dbn_item_t;

  typedef struct packed {
    logic [6:0]         box_class;
    logic [15:0]        box_confidence;
    logic signed [15:0] box_x;
    logic signed [15:0] box_y;
    logic [14:0]        box_w;
    logic [14:0]        box_h;
    logic               box_valid;
    logic               overflow;
    logic               last_box;
  } dbn_result_t;

  typedef struct packed {
    logic [15:0] conf_threshold;
    logic [15:0] iou_threshold;
    logic [11:0] offset_x;
    logic [11:0] offset_y;
    logic [15:0] scale_x;
    logic [15:0] scale_y;
  } dbn_cfg_t;

  typedef struct packed {
    logic               valid;
    logic               sup;
    logic [15:0]        conf;
    logic [6:0]         cls;
    logic signed [15:0] x;
    logic signed [15:0] y;
    logic [14:0]        w;
    logic [14:0]        h;
  } dbn_entry_t;

  typedef enum logic [1:0] {
    CELL_HOLD,
    CELL_INSERT,
    CELL_POP,
    CELL_ROT
  } dbn_cell_op_t;

  typedef struct packed {
    dbn_cell_op_t op;
    dbn_entry_t   new_e;
  } dbn_cell_ctl_t;

endpackage

// ===== src/dbn_decode.sv =====
// ----------------------------------------------------------------------------
// dbn_decode: cell decode pipeline
// Removes the crop offset, scales, forms corners and saturates; three stages.
// ----------------------------------------------------------------------------
module dbn_decode import dbn_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  input  dbn_item_t  item,
  input  dbn_cfg_t   cfg,
  output logic       dec_valid,
  output logic       dec_keep,
  output logic       dec_frame_end,
  output dbn_entry_t dec_entry,
  output logic       pending_end
);

  function automatic logic signed [15:0] sat_pos(input logic signed [18:0] v);
    logic signed [15:0] r;
    if (v < -19'sd32768) r = -16'sd32768;
    else if (v > 19'sd32767) r = 16'sd32767;
    else r = v[15:0];
    return r;
  endfunction

  dbn_item_t   it0;
  logic        v0;

  logic        v1, keep1, fe1, negx1, negy1;
  logic [16:0] qx1, qy1;
  logic [15:0] w1, h1, conf1;
  logic [6:0]  cls1;

  logic        v2;

  logic signed [17:0] dx, dy;
  logic [16:0]        magx, magy;
  logic [32:0]        prodx, prody;
  logic [31:0]        prodw, prodh;
  logic signed [17:0] cx, cy;
  logic signed [18:0] xs, ys;

  assign dx    = $signed({2'b00, it0.raw_cx}) - $signed({2'b00, cfg.offset_x, 4'b0000});
  assign dy    = $signed({2'b00, it0.raw_cy}) - $signed({2'b00, cfg.offset_y, 4'b0000});
  assign magx  = dx[17] ? 17'(-dx) : dx[16:0];
  assign magy  = dy[17] ? 17'(-dy) : dy[16:0];
  assign prodx = magx * cfg.scale_x;
  assign prody = magy * cfg.scale_y;
  assign prodw = it0.raw_w * cfg.scale_x;
  assign prodh = it0.raw_h * cfg.scale_y;

  assign cx = negx1 ? -$signed({1'b0, qx1}) : $signed({1'b0, qx1});
  assign cy = negy1 ? -$signed({1'b0, qy1}) : $signed({1'b0, qy1});
  assign xs = $signed({cx[17], cx}) - $signed({4'b0000, w1[15:1]});
  assign ys = $signed({cy[17], cy}) - $signed({4'b0000, h1[15:1]});

  always_ff @(posedge clk) begin
    if (rst) begin
      v0 <= 1'b0;
      v1 <= 1'b0;
      v2 <= 1'b0;
    end else begin
      v0 <= in_valid;
      v1 <= v0;
      v2 <= v1;
    end
    if (in_valid) it0 <= item;
    negx1 <= dx[17];
    negy1 <= dy[17];
    qx1   <= prodx[32:16];
    qy1   <= prody[32:16];
    w1    <= prodw[31:16];
    h1    <= prodh[31:16];
    conf1 <= it0.confidence;
    cls1  <= it0.class_id;
    keep1 <= it0.confidence >= cfg.conf_threshold;
    fe1   <= it0.frame_end;

    dec_keep        <= keep1;
    dec_frame_end   <= fe1;
    dec_entry.valid <= 1'b1;
    dec_entry.sup   <= 1'b0;
    dec_entry.conf  <= conf1;
    dec_entry.cls   <= cls1;
    dec_entry.x     <= sat_pos(xs);
    dec_entry.y     <= sat_pos(ys);
    dec_entry.w     <= w1[15] ? 15'h7fff : w1[14:0];
    dec_entry.h     <= h1[15] ? 15'h7fff : h1[14:0];
  end

  assign dec_valid   = v2;
  assign pending_end = (v0 && it0.frame_end) || (v1 && fe1) || (v2 && dec_frame_end);

endmodule

// ===== src/dbn_cell.sv =====
// ----------------------------------------------------------------------------
// dbn_cell: one slot of the sorted box chain
// Keeps its box, takes the new box or its left neighbour on insert, and
// takes its right neighbour on pop and rotate; on rotate the tail slot takes the head box back.
// ----------------------------------------------------------------------------
module dbn_cell import dbn_pkg::*; (
  input  logic          clk,
  input  logic          rst,
  input  dbn_cell_ctl_t ctl,
  input  dbn_entry_t    prev_e,
  input  logic          prev_keeps,
  input  dbn_entry_t    next_e,
  input  dbn_entry_t    wrap_e,
  input  logic          is_tail,
  output dbn_entry_t    ent,
  output logic          keeps
);

  // ties count as higher, so an equal stored box stays ahead
  assign keeps = ent.valid && (ent.conf >= ctl.new_e.conf);

  always_ff @(posedge clk) begin
    if (rst) begin
      ent.valid <= 1'b0;
    end else begin
      case (ctl.op)
        CELL_INSERT: begin
          if (!keeps) ent <= prev_keeps ? ctl.new_e : prev_e;
        end
        CELL_POP: ent <= next_e;
        CELL_ROT: ent <= is_tail ? wrap_e : next_e;
        default: ;
      endcase
    end
  end

endmodule

// ===== src/dbn_iou.sv =====
// ----------------------------------------------------------------------------
// dbn_iou: overlap test
// Four-stage pipeline deciding whether box b overlaps kept box a of the
// same class by more than the IoU threshold, by cross-multiplication.
// ----------------------------------------------------------------------------
module dbn_iou import dbn_pkg::*; (
  input  logic        clk,
  input  dbn_entry_t  a,
  input  dbn_entry_t  b,
  input  logic [15:0] iou_threshold,
  output logic        supp
);

  logic signed [16:0] ra, rb, ba, bb, l, r, t, btm;
  logic signed [17:0] dx, dy;

  logic [14:0] dx0, dy0, wa0, ha0, wb0, hb0;
  logic        ok0, ok1, ok2, ok3;
  logic [29:0] inter1, aa1, ab1, inter2;
  logic [30:0] uni2;
  logic [46:0] lhs3, rhs3;

  assign ra  = $signed({a.x[15], a.x}) + $signed({2'b00, a.w});
  assign rb  = $signed({b.x[15], b.x}) + $signed({2'b00, b.w});
  assign ba  = $signed({a.y[15], a.y}) + $signed({2'b00, a.h});
  assign bb  = $signed({b.y[15], b.y}) + $signed({2'b00, b.h});
  assign l   = (a.x > b.x) ? $signed({a.x[15], a.x}) : $signed({b.x[15], b.x});
  assign t   = (a.y > b.y) ? $signed({a.y[15], a.y}) : $signed({b.y[15], b.y});
  assign r   = (ra < rb) ? ra : rb;
  assign btm = (ba < bb) ? ba : bb;
  assign dx  = $signed({r[16], r}) - $signed({l[16], l});
  assign dy  = $signed({btm[16], btm}) - $signed({t[16], t});

  always_ff @(posedge clk) begin
    // span never exceeds the narrower box, so 15 bits hold it
    ok0 <= (a.cls == b.cls) && !dx[17] && !dy[17];
    dx0 <= dx[14:0];
    dy0 <= dy[14:0];
    wa0 <= a.w;
    ha0 <= a.h;
    wb0 <= b.w;
    hb0 <= b.h;

    ok1    <= ok0;
    inter1 <= dx0 * dy0;
    aa1    <= wa0 * ha0;
    ab1    <= wb0 * hb0;

    ok2    <= ok1;
    inter2 <= inter1;
    uni2   <= {1'b0, aa1} + {1'b0, ab1} - {1'b0, inter1};

    ok3  <= ok2;
    lhs3 <= {1'b0, inter2, 16'h0000};
    rhs3 <= iou_threshold * uni2;
  end

  assign supp = ok3 && (lhs3 > rhs3);

endmodule

// ===== src/detection_box_decode_nms_top.sv =====
// ----------------------------------------------------------------------------
// detection_box_decode_nms_top: box decode with per-class suppression
// Decodes detector cells into boxes, keeps them in a sorted cell chain and
// runs greedy same-class suppression at the end of each frame.
// ----------------------------------------------------------------------------
// Usage: raise start with one grid cell on item; it is taken when busy is
// low. Ordinary cells are taken one per cycle and give no result. A cell with
// frame_end set raises busy; once it has passed the decode pipeline into the
// cell chain, suppression begins. The chain is popped from its head: a
// suppressed box is dropped, and a kept box is held and tested against each
// box still behind it (one overlap test through the four-stage IoU pipeline,
// then a rotate of the chain). Each kept box appears on result for one cycle
// with result_valid high; the last carries last_box, or a single marker with
// box_valid low appears when nothing survived. The receiver cannot stall.
// busy falls in the cycle of the last result. Configuration writes on cfg_*
// are always ready and are meant for idle periods. Reset clears the chain,
// the count, the overflow flag and restores the register defaults.
// ----------------------------------------------------------------------------
module detection_box_decode_nms_top import dbn_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  dbn_item_t   item,
  output logic        busy,
  output logic        result_valid,
  output dbn_result_t result,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [15:0] cfg_data
);

  typedef enum logic [1:0] {ST_COLLECT, ST_POP, ST_CMP} state_t;

  state_t            state;
  dbn_cfg_t          cfg;
  logic [COUNT_W-1:0] count;
  logic [COUNT_W-1:0] rot_left;
  logic [2:0]        step;
  logic              overflow_seen;
  logic              pend_valid;
  dbn_entry_t        pend;
  logic              emit;

  logic       dec_valid, dec_keep, dec_frame_end, pending_end, supp;
  dbn_entry_t dec_entry, wrap_e;
  dbn_cell_ctl_t ctl;

  dbn_entry_t ent   [MAX_BOXES];
  logic       keeps [MAX_BOXES];

  assign cfg_ready = 1'b1;
  assign busy      = (state != ST_COLLECT) || pending_end;
  assign emit      = (state == ST_POP) && ((count == '0) || (!ent[0].sup && pend_valid));

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.conf_threshold <= 16'd16384;
      cfg.iou_threshold  <= 16'd29491;
      cfg.offset_x       <= 12'd0;
      cfg.offset_y       <= 12'd0;
      cfg.scale_x        <= 16'd4096;
      cfg.scale_y        <= 16'd4096;
    end else if (cfg_valid) begin
      case (cfg_index)
        CFG_CONF_THR: cfg.conf_threshold <= cfg_data;
        CFG_IOU_THR:  cfg.iou_threshold  <= cfg_data;
        CFG_OFFSET_X: cfg.offset_x       <= cfg_data[11:0];
        CFG_OFFSET_Y: cfg.offset_y       <= cfg_data[11:0];
        CFG_SCALE_X:  cfg.scale_x        <= cfg_data;
        CFG_SCALE_Y:  cfg.scale_y        <= cfg_data;
        default: ;
      endcase
    end
  end

  dbn_decode u_decode (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (start && !busy),
    .item          (item),
    .cfg           (cfg),
    .dec_valid     (dec_valid),
    .dec_keep      (dec_keep),
    .dec_frame_end (dec_frame_end),
    .dec_entry     (dec_entry),
    .pending_end   (pending_end)
  );

  dbn_iou u_iou (
    .clk           (clk),
    .a             (pend),
    .b             (ent[0]),
    .iou_threshold (cfg.iou_threshold),
    .supp          (supp)
  );

  always_comb begin
    wrap_e     = ent[0];
    wrap_e.sup = ent[0].sup || supp;
    ctl.new_e  = dec_entry;
    ctl.op     = CELL_HOLD;
    case (state)
      ST_COLLECT: if (dec_valid && dec_keep) ctl.op = CELL_INSERT;
      ST_POP:     if (count != '0) ctl.op = CELL_POP;
      ST_CMP:     if (step == 3'd4) ctl.op = CELL_ROT;
      default: ;
    endcase
  end

  for (genvar g = 0; g < MAX_BOXES; g++) begin : g_cell
    dbn_entry_t prev_e, next_e;
    logic       prev_keeps;
    if (g == 0) begin : g_head
      assign prev_e     = '0;
      assign prev_keeps = 1'b1;
    end else begin : g_mid
      assign prev_e     = ent[g-1];
      assign prev_keeps = keeps[g-1];
    end
    if (g == MAX_BOXES - 1) begin : g_end
      assign next_e = '0;
    end else begin : g_nxt
      assign next_e = ent[g+1];
    end
    dbn_cell u_cell (
      .clk        (clk),
      .rst        (rst),
      .ctl        (ctl),
      .prev_e     (prev_e),
      .prev_keeps (prev_keeps),
      .next_e     (next_e),
      .wrap_e     (wrap_e),
      .is_tail    (count == COUNT_W'(g + 1)),
      .ent        (ent[g]),
      .keeps      (keeps[g])
    );
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_COLLECT;
      count         <= '0;
      overflow_seen <= 1'b0;
      pend_valid    <= 1'b0;
      result_valid  <= 1'b0;
      rot_left      <= '0;
      step          <= '0;
    end else begin
      result_valid <= emit;
      case (state)
        ST_COLLECT: begin
          if (dec_valid) begin
            if (dec_keep) begin
              if (count == COUNT_W'(MAX_BOXES)) overflow_seen <= 1'b1;
              else count <= count + 1'b1;
            end
            if (dec_frame_end) state <= ST_POP;
          end
        end
        ST_POP: begin
          if (count == '0) begin
            // flush the held box as the final transfer, or the empty marker
            result.box_class      <= pend_valid ? pend.cls : '0;
            result.box_confidence <= pend_valid ? pend.conf : '0;
            result.box_x          <= pend_valid ? pend.x : '0;
            result.box_y          <= pend_valid ? pend.y : '0;
            result.box_w          <= pend_valid ? pend.w : '0;
            result.box_h          <= pend_valid ? pend.h : '0;
            result.box_valid      <= pend_valid;
            result.overflow       <= overflow_seen;
            result.last_box       <= 1'b1;
            pend_valid    <= 1'b0;
            overflow_seen <= 1'b0;
            state         <= ST_COLLECT;
          end else begin
            count <= count - 1'b1;
            if (!ent[0].sup) begin
              if (pend_valid) begin
                result.box_class      <= pend.cls;
                result.box_confidence <= pend.conf;
                result.box_x          <= pend.x;
                result.box_y          <= pend.y;
                result.box_w          <= pend.w;
                result.box_h          <= pend.h;
                result.box_valid      <= 1'b1;
                result.overflow       <= overflow_seen;
                result.last_box       <= 1'b0;
              end
              pend       <= ent[0];
              pend_valid <= 1'b1;
              if (count != COUNT_W'(1)) begin
                rot_left <= count - 1'b1;
                step     <= '0;
                state    <= ST_CMP;
              end
            end
          end
        end
        ST_CMP: begin
          if (step == 3'd4) begin
            step     <= '0;
            rot_left <= rot_left - 1'b1;
            if (rot_left == COUNT_W'(1)) state <= ST_POP;
          end else begin
            step <= step + 1'b1;
          end
        end
        default: state <= ST_COLLECT;
      endcase
    end
  end

`ifndef NO_ASSERTIONS
  a_count_range: assert property (@(posedge clk) disable iff (rst)
    count <= COUNT_W'(MAX_BOXES))
    else $error("box count beyond capacity");

  a_marker_last: assert property (@(posedge clk) disable iff (rst)
    result_valid && !result.box_valid |-> result.last_box)
    else $error("empty marker not final");

  a_last_gap: assert property (@(posedge clk) disable iff (rst)
    result_valid && result.last_box |=> !result_valid)
    else $error("transfer after end of frame");
`endif

endmodule

// ===== tb/dbn_checker.sv =====
// ----------------------------------------------------------------------------
// dbn_checker: frame predictor and result checker
// Watches accepted cells and configuration transfers, predicts the kept boxes
// of each frame and compares every result strobe with the oldest prediction.
// ----------------------------------------------------------------------------
module dbn_checker import dbn_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  dbn_item_t   item,
  input  logic        busy,
  input  logic        result_valid,
  input  dbn_result_t result,
  input  logic        cfg_valid,
  input  logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [15:0] cfg_data,
  output int          fail_count,
  output int          pending_boxes
);

  typedef struct {
    longint x, y, w, h;
    int unsigned conf, cls;
  } cand_t;

  dbn_cfg_t    regs;
  cand_t       sorted_boxes[$];
  bit          dropped_any;
  dbn_result_t expected_boxes[$];

  assign pending_boxes = expected_boxes.size();

  function automatic longint clamp(longint v, longint lo, longint hi);
    if (v < lo) return lo;
    if (v > hi) return hi;
    return v;
  endfunction

  function automatic longint centre_of(longint raw, longint off, longint scale);
    longint d, q;
    d = raw - off * 16;
    q = ((d < 0 ? -d : d) * scale) >>> 16;
    return d < 0 ? -q : q;
  endfunction

  function automatic bit overlaps(cand_t a, cand_t b);
    longint l, r, t, btm, inter, uni;
    l = a.x > b.x ? a.x : b.x;
    r = (a.x + a.w) < (b.x + b.w) ? a.x + a.w : b.x + b.w;
    t = a.y > b.y ? a.y : b.y;
    btm = (a.y + a.h) < (b.y + b.h) ? a.y + a.h : b.y + b.h;
    if (l > r || t > btm) return 0;
    inter = (r - l) * (btm - t);
    uni = a.w * a.h + b.w * b.h - inter;
    return inter * 65536 > longint'(regs.iou_threshold) * uni;
  endfunction

  task automatic report(string what, dbn_result_t got, dbn_result_t want);
    $display("mismatch %s: got %h want %h at %0t", what, got, want, $realtime);
    fail_count++;
  endtask

  task automatic take_cell(dbn_item_t c);
    cand_t b;
    longint cx, cy, w, h;
    int pos;
    bit kill[];
    dbn_result_t r;
    int n;
    if (c.confidence >= regs.conf_threshold) begin
      cx = centre_of(c.raw_cx, regs.offset_x, regs.scale_x);
      cy = centre_of(c.raw_cy, regs.offset_y, regs.scale_y);
      w = (longint'(c.raw_w) * regs.scale_x) >>> 16;
      h = (longint'(c.raw_h) * regs.scale_y) >>> 16;
      b.x = clamp(cx - w / 2, -32768, 32767);
      b.y = clamp(cy - h / 2, -32768, 32767);
      b.w = clamp(w, 0, 32767);
      b.h = clamp(h, 0, 32767);
      b.conf = c.confidence;
      b.cls = c.class_id;
      pos = 0;
      while (pos < sorted_boxes.size() && sorted_boxes[pos].conf >= b.conf) pos++;
      if (sorted_boxes.size() == MAX_BOXES) begin
        dropped_any = 1;
        if (pos < MAX_BOXES) begin
          void'(sorted_boxes.pop_back());
          sorted_boxes.insert(pos, b);
        end
      end else begin
        sorted_boxes.insert(pos, b);
      end
    end
    if (!c.frame_end) return;
    n = 0;
    kill = new[sorted_boxes.size()];
    foreach (sorted_boxes[i]) begin
      if (kill[i]) continue;
      for (int j = i + 1; j < sorted_boxes.size(); j++)
        if (sorted_boxes[j].cls == sorted_boxes[i].cls && overlaps(sorted_boxes[i], sorted_boxes[j]))
          kill[j] = 1;
      r = '0;
      r.box_class = 7'(sorted_boxes[i].cls);
      r.box_confidence = 16'(sorted_boxes[i].conf);
      r.box_x = 16'(sorted_boxes[i].x);
      r.box_y = 16'(sorted_boxes[i].y);
      r.box_w = 15'(sorted_boxes[i].w);
      r.box_h = 15'(sorted_boxes[i].h);
      r.box_valid = 1;
      r.overflow = dropped_any;
      expected_boxes = {expected_boxes, r};
      n++;
    end
    if (n == 0) begin
      r = '0;
      r.overflow = dropped_any;
      expected_boxes = {expected_boxes, r};
    end
    expected_boxes[expected_boxes.size() - 1].last_box = 1;
    sorted_boxes.delete();
    dropped_any = 0;
  endtask

  always @(posedge clk) begin
    if (rst) begin
      regs <= '{16'd16384, 16'd29491, 12'd0, 12'd0, 16'd4096, 16'd4096};
      sorted_boxes.delete();
      expected_boxes.delete();
      dropped_any = 0;
      fail_count = 0;
    end else begin
      // results first: a frame's own predictions cannot appear in the same cycle
      if (result_valid) begin
        if (expected_boxes.size() == 0) begin
          report("unexpected result", result, '0);
        end else if (result !== expected_boxes[0]) begin
          report("result fields", result, expected_boxes[0]);
          void'(expected_boxes.pop_front());
        end else begin
          void'(expected_boxes.pop_front());
        end
      end
      if (start && !busy) take_cell(item);
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_CONF_THR: regs.conf_threshold <= cfg_data;
          CFG_IOU_THR:  regs.iou_threshold  <= cfg_data;
          CFG_OFFSET_X: regs.offset_x       <= cfg_data[11:0];
          CFG_OFFSET_Y: regs.offset_y       <= cfg_data[11:0];
          CFG_SCALE_X:  regs.scale_x        <= cfg_data;
          CFG_SCALE_Y:  regs.scale_y        <= cfg_data;
          default: ;
        endcase
      end
    end
  end

endmodule

// ===== tb/testbench.sv =====
// ----------------------------------------------------------------------------
// testbench: stimulus and verdict for the box decode and suppression block
// Sends directed and random frames in bursts under several register
// settings; the checker beside the block predicts and compares results.
// ----------------------------------------------------------------------------
module testbench;
  import dbn_pkg::*;

  logic        clk = 0;
  logic        rst = 1;
  logic        start = 0;
  dbn_item_t   item = '0;
  logic        busy, result_valid, cfg_ready;
  dbn_result_t result;
  logic        cfg_valid = 0;
  logic [2:0]  cfg_index = '0;
  logic [15:0] cfg_data = '0;
  int          fail_count, pending_boxes;
  longint      cycle_count = 0;
  int          items_sent = 0;

  always #10 clk = ~clk;

  detection_box_decode_nms_top DUT (.*);

  dbn_checker u_checker (.*);

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > 3000000) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  task automatic send_cell(dbn_item_t c);
    item <= c;
    start <= 1;
    @(posedge clk);
    while (busy) @(posedge clk);
    items_sent++;
    // random gap between bursts
    if ($urandom_range(0, 3) == 0) begin
      start <= 0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
  endtask

  task automatic finish_frame();
    start <= 0;
    @(posedge clk);
    while (busy || pending_boxes != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_reg(logic [2:0] idx, logic [15:0] val);
    cfg_index <= idx;
    cfg_data <= val;
    cfg_valid <= 1;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 0;
    @(posedge clk);
  endtask

  function automatic dbn_item_t rand_cell(bit last, bit clustered);
    dbn_item_t c;
    c.raw_cx = clustered ? 16'(1000 + $urandom_range(0, 200)) : 16'($urandom);
    c.raw_cy = clustered ? 16'(1000 + $urandom_range(0, 200)) : 16'($urandom);
    c.raw_w = clustered ? 16'($urandom_range(200, 900)) : 16'($urandom);
    c.raw_h = clustered ? 16'($urandom_range(200, 900)) : 16'($urandom);
    c.confidence = $urandom_range(0, 3) == 0 ? 16'($urandom_range(16380, 16390))
                                             : 16'($urandom);
    c.class_id = clustered ? 7'($urandom_range(0, 2)) : 7'($urandom);
    c.frame_end = last;
    return c;
  endfunction

  task automatic random_frame(int len);
    bit clustered;
    clustered = $urandom_range(0, 3) != 0;
    for (int i = 0; i < len; i++) send_cell(rand_cell(i == len - 1, clustered));
    finish_frame();
  endtask

  initial begin
    repeat (7) @(posedge clk);
    rst <= 0;
    @(posedge clk);
    // directed: extremes, ties, zero area, overlap pair, empty frame
    send_cell('{16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 7'h7F, 1'b0});
    send_cell('{16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h4000, 7'h00, 1'b0});
    send_cell('{16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h4000, 7'h00, 1'b0});
    send_cell('{16'd800, 16'd800, 16'd400, 16'd400, 16'h9000, 7'h05, 1'b0});
    send_cell('{16'd810, 16'd805, 16'd400, 16'd400, 16'h8000, 7'h05, 1'b0});
    send_cell('{16'd810, 16'd805, 16'd400, 16'd400, 16'h8000, 7'h06, 1'b0});
    send_cell('{16'd5, 16'd5, 16'd5, 16'd5, 16'h3FFF, 7'h01, 1'b1});
    finish_frame();
    send_cell('{16'd5, 16'd5, 16'd5, 16'd5, 16'h0001, 7'h01, 1'b1});
    finish_frame();
    // extreme scales and offsets, negative centres
    write_reg(CFG_OFFSET_X, 16'hFFFF);
    write_reg(CFG_OFFSET_Y, 16'h0FFF);
    write_reg(CFG_SCALE_X, 16'hFFFF);
    write_reg(CFG_SCALE_Y, 16'hFFFF);
    write_reg(3'd7, 16'h1234);
    send_cell('{16'h0000, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 7'h02, 1'b0});
    send_cell('{16'hFFFF, 16'h0000, 16'h0001, 16'h0000, 16'h8000, 7'h02, 1'b1});
    finish_frame();
    // everything kept, full list overflow
    write_reg(CFG_CONF_THR, 16'h0000);
    write_reg(CFG_IOU_THR, 16'hFFFF);
    write_reg(CFG_SCALE_X, 16'h0000);
    write_reg(CFG_SCALE_Y, 16'h1000);
    for (int i = 0; i < 70; i++) send_cell(rand_cell(i == 69, 0));
    finish_frame();
    write_reg(CFG_OFFSET_X, 16'd0);
    write_reg(CFG_OFFSET_Y, 16'd0);
    write_reg(CFG_SCALE_X, 16'h1000);
    write_reg(CFG_IOU_THR, 16'h0000);
    random_frame(20);
    write_reg(CFG_CONF_THR, 16'hFFFF);
    random_frame(6);
    // random settings and frames
    while (items_sent < 230) begin
      write_reg(CFG_CONF_THR, 16'($urandom_range(0, 40000)));
      write_reg(CFG_IOU_THR, 16'($urandom));
      write_reg(CFG_OFFSET_X, 16'($urandom_range(0, 80)));
      write_reg(CFG_OFFSET_Y, 16'($urandom_range(0, 80)));
      write_reg(CFG_SCALE_X, 16'($urandom_range(2048, 12000)));
      write_reg(CFG_SCALE_Y, 16'($urandom_range(2048, 12000)));
      random_frame($urandom_range(1, 14));
    end
    repeat (20) @(posedge clk);
    if (fail_count == 0 && pending_boxes == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
